// ----- rtl/sdmc_pkg.sv -----
// shared types and constants of the system device memory copy unit
// no dependencies; used by sdmc_ctrl, sdmc_datapath and the top level
package sdmc_pkg;

  localparam int ADDR_W = 20;
  localparam int BYTE_W = 8;
  localparam int OFFS_W = 16;
  localparam int PAGE_BITS = ADDR_W - OFFS_W;
  localparam int PAGE_COUNT_DEFAULT = 16;
  localparam int NUM_PORTS = 16;
  localparam int PORT_W = 4;
  localparam int HDR_BYTES = 10;
  localparam int HDR_IDX_W = 4;
  localparam int IN_DATA_W = 32;
  localparam int IN_USER_W = 2;

  // access kinds
  localparam logic [1:0] ACT_RAM_WR  = 2'd0;
  localparam logic [1:0] ACT_RAM_RD  = 2'd1;
  localparam logic [1:0] ACT_PORT_WR = 2'd2;
  localparam logic [1:0] ACT_PORT_RD = 2'd3;

  // device ports
  localparam logic [PORT_W-1:0] PORT_BLK_HI = 4'd2;
  localparam logic [PORT_W-1:0] PORT_BLK_LO = 4'd3;
  localparam logic [PORT_W-1:0] PORT_COPY   = 4'd3;
  localparam logic [PORT_W-1:0] PORT_WSP    = 4'd4;
  localparam logic [PORT_W-1:0] PORT_RSP    = 4'd5;

  localparam logic [BYTE_W-1:0] CMD_COPY = 8'h01;

  // memory address sources
  localparam logic [1:0] ASEL_ITEM = 2'd0;
  localparam logic [1:0] ASEL_HDR  = 2'd1;
  localparam logic [1:0] ASEL_SRC  = 2'd2;
  localparam logic [1:0] ASEL_DST  = 2'd3;

  typedef logic [1:0] action_t;
  typedef logic [1:0] addr_sel_t;

  typedef struct packed {
    logic      load_item;
    logic      reg_write;
    logic      mem_rd;
    logic      mem_wr;
    addr_sel_t addr_sel;
    logic      copy_init;
    logic      hdr_capture;
    logic      mod_step;
    logic      idx_step;
    logic      out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    action_t act;
    logic    port_is_copy;
    logic    hdr_first;
    logic    first_ok;
    logic    hdr_done;
    logic    mod_last;
    logic    len_zero;
    logic    copy_last;
    logic    out_free;
  } dp_status_t;

endpackage

// ----- rtl/sdmc_ctrl.sv -----
// controller state machine of the system device memory copy unit
// depends on sdmc_pkg; drives sdmc_datapath through ctrl_cmd_t
module sdmc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  sdmc_pkg::dp_status_t status,
  output sdmc_pkg::ctrl_cmd_t  cmd
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_EXEC    = 4'd1;
  localparam logic [3:0] ST_CP_HRD  = 4'd2;
  localparam logic [3:0] ST_CP_HCAP = 4'd3;
  localparam logic [3:0] ST_CP_MOD  = 4'd4;
  localparam logic [3:0] ST_CP_SRD  = 4'd5;
  localparam logic [3:0] ST_CP_DWR  = 4'd6;
  localparam logic [3:0] ST_FINISH  = 4'd7;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.addr_sel = sdmc_pkg::ASEL_ITEM;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_FINISH;
        unique case (status.act)
          sdmc_pkg::ACT_RAM_WR: cmd.mem_wr = 1'b1;
          sdmc_pkg::ACT_RAM_RD: cmd.mem_rd = 1'b1;
          sdmc_pkg::ACT_PORT_WR: begin
            cmd.reg_write = 1'b1;
            if (status.port_is_copy) begin
              cmd.copy_init = 1'b1;
              state_next = ST_CP_HRD;
            end
          end
          default: ;
        endcase
      end
      ST_CP_HRD: begin
        cmd.mem_rd = 1'b1;
        cmd.addr_sel = sdmc_pkg::ASEL_HDR;
        state_next = ST_CP_HCAP;
      end
      ST_CP_HCAP: begin
        cmd.hdr_capture = 1'b1;
        priority if (status.hdr_first && !status.first_ok) begin
          state_next = ST_FINISH;
        end else if (status.hdr_done) begin
          state_next = ST_CP_MOD;
        end else begin
          state_next = ST_CP_HRD;
        end
      end
      ST_CP_MOD: begin
        cmd.mod_step = 1'b1;
        if (status.mod_last) begin
          state_next = status.len_zero ? ST_FINISH : ST_CP_SRD;
        end
      end
      ST_CP_SRD: begin
        cmd.mem_rd = 1'b1;
        cmd.addr_sel = sdmc_pkg::ASEL_SRC;
        state_next = ST_CP_DWR;
      end
      ST_CP_DWR: begin
        cmd.mem_wr = 1'b1;
        cmd.addr_sel = sdmc_pkg::ASEL_DST;
        cmd.idx_step = 1'b1;
        state_next = status.copy_last ? ST_FINISH : ST_CP_SRD;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // an accepted transaction always goes on to execute
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_EXEC))
    else $error("accepted transaction did not enter execute");

  // every copy write is preceded by its source read
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CP_DWR) |-> ($past(state) == ST_CP_SRD))
    else $error("copy write without source read");

  // loading the result returns the controller to idle
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> (state == ST_IDLE))
    else $error("result loaded but controller not idle");

endmodule

// ----- rtl/sdmc_datapath.sv -----
// datapath of the system device memory copy unit: paged byte memory,
// device registers, copy header, page modulo unit and result register; depends on sdmc_pkg
module sdmc_datapath #(
  parameter int PAGE_COUNT = sdmc_pkg::PAGE_COUNT_DEFAULT
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [sdmc_pkg::IN_USER_W-1:0]         s_tuser,
  input  logic [sdmc_pkg::IN_DATA_W-1:0]         s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [sdmc_pkg::BYTE_W-1:0]            m_tdata,
  input  sdmc_pkg::ctrl_cmd_t                    cmd,
  output sdmc_pkg::dp_status_t                   status
);

  localparam int AW = sdmc_pkg::ADDR_W;
  localparam int BW = sdmc_pkg::BYTE_W;
  localparam int OW = sdmc_pkg::OFFS_W;
  localparam int PB = sdmc_pkg::PAGE_BITS;
  localparam int HW = sdmc_pkg::HDR_BYTES * BW;
  localparam logic [PB:0] PAGE_N = (PB + 1)'(PAGE_COUNT);
  // reciprocal of the page count, exact for every 16 bit page number
  localparam int RSH = OW + PB + 1;
  localparam int PW = OW + RSH + 1;
  localparam logic [RSH:0] RECIP = (RSH + 1)'(((1 << RSH) + PAGE_COUNT - 1) / PAGE_COUNT);
  localparam logic [OW-1:0] PAGE_N_W = OW'(PAGE_COUNT);

  // latched transaction
  sdmc_pkg::action_t act;
  logic [AW-1:0] addr;
  logic [BW-1:0] wdata;
  logic [sdmc_pkg::PORT_W-1:0] port;

  // device registers
  logic [BW-1:0] regs [sdmc_pkg::NUM_PORTS];
  logic [BW-1:0] work_stack_ptr;
  logic [BW-1:0] return_stack_ptr;
  logic [BW-1:0] port_val;

  // memory
  logic [BW-1:0] mem [2**AW];
  logic [BW-1:0] mem_rdata;
  logic [AW-1:0] mem_addr;
  logic [BW-1:0] mem_wdata;

  // copy state
  logic [sdmc_pkg::HDR_IDX_W-1:0] hdr_idx;
  logic [HW-1:0] hdr;
  logic [OW-1:0] cp_len, cp_spage, cp_saddr, cp_dpage, cp_daddr;
  logic mod_cnt;
  logic [PB-1:0] src_pg, dst_pg;
  logic [OW-1:0] src_quo, dst_quo;
  logic [PW-1:0] src_prod, dst_prod;
  logic [OW-1:0] src_rem, dst_rem;
  logic [OW-1:0] copy_idx;
  logic [AW-1:0] blk_addr;
  logic [BW-1:0] result;

  assign port = addr[sdmc_pkg::PORT_W-1:0];
  assign {cp_len, cp_spage, cp_saddr, cp_dpage, cp_daddr} = hdr;
  assign blk_addr = {{(AW-2*BW){1'b0}}, regs[sdmc_pkg::PORT_BLK_HI], regs[sdmc_pkg::PORT_BLK_LO]};

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act <= s_tuser;
      addr <= s_tdata[AW-1:0];
      wdata <= s_tdata[AW+BW-1:AW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sdmc_pkg::NUM_PORTS; i++) begin
        regs[i] <= '0;
      end
      work_stack_ptr <= '0;
      return_stack_ptr <= '0;
    end else if (cmd.reg_write) begin
      regs[port] <= wdata;
      if (port == sdmc_pkg::PORT_WSP) begin
        work_stack_ptr <= wdata;
      end
      if (port == sdmc_pkg::PORT_RSP) begin
        return_stack_ptr <= wdata;
      end
    end
  end

  always_comb begin
    unique case (port)
      sdmc_pkg::PORT_WSP: port_val = work_stack_ptr;
      sdmc_pkg::PORT_RSP: port_val = return_stack_ptr;
      default:            port_val = regs[port];
    endcase
  end

  always_comb begin
    unique case (cmd.addr_sel)
      sdmc_pkg::ASEL_ITEM: mem_addr = addr;
      sdmc_pkg::ASEL_HDR:  mem_addr = blk_addr + AW'(hdr_idx);
      sdmc_pkg::ASEL_SRC:  mem_addr = {src_pg, OW'(cp_saddr + copy_idx)};
      default:             mem_addr = {dst_pg, OW'(cp_daddr + copy_idx)};
    endcase
    mem_wdata = (cmd.addr_sel == sdmc_pkg::ASEL_DST) ? mem_rdata : wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (cmd.mem_rd) begin
      mem_rdata <= mem[mem_addr];
    end
  end

  // page modulo by reciprocal multiplication: quotient first, remainder on the next step
  assign src_prod = PW'(cp_spage) * PW'(RECIP);
  assign dst_prod = PW'(cp_dpage) * PW'(RECIP);
  assign src_rem = cp_spage - src_quo * PAGE_N_W;
  assign dst_rem = cp_dpage - dst_quo * PAGE_N_W;

  // header capture, page modulo and copy index
  always_ff @(posedge clk) begin
    if (rst || cmd.copy_init) begin
      hdr_idx <= '0;
      mod_cnt <= 1'b0;
      src_quo <= '0;
      dst_quo <= '0;
      src_pg <= '0;
      dst_pg <= '0;
      copy_idx <= '0;
    end else begin
      if (cmd.hdr_capture) begin
        hdr_idx <= hdr_idx + 1'b1;
      end
      if (cmd.mod_step) begin
        mod_cnt <= ~mod_cnt;
        if (mod_cnt) begin
          src_pg <= src_rem[PB-1:0];
          dst_pg <= dst_rem[PB-1:0];
        end else begin
          src_quo <= src_prod[RSH +: OW];
          dst_quo <= dst_prod[RSH +: OW];
        end
      end
      if (cmd.idx_step) begin
        copy_idx <= copy_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hdr_capture) begin
      hdr <= {hdr[HW-BW-1:0], mem_rdata};
    end
  end

  // result register
  always_comb begin
    unique case (act)
      sdmc_pkg::ACT_RAM_RD:  result = mem_rdata;
      sdmc_pkg::ACT_PORT_RD: result = port_val;
      default:               result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= result;
    end
  end

  always_comb begin
    status.act = act;
    status.port_is_copy = (port == sdmc_pkg::PORT_COPY);
    status.hdr_first = (hdr_idx == '0);
    status.first_ok = (mem_rdata == sdmc_pkg::CMD_COPY);
    status.hdr_done = (hdr_idx == sdmc_pkg::HDR_IDX_W'(sdmc_pkg::HDR_BYTES));
    status.mod_last = mod_cnt;
    status.len_zero = (cp_len == '0);
    status.copy_last = ((OW + 1)'(copy_idx) + 1'b1) == {1'b0, cp_len};
    status.out_free = !m_tvalid || m_tready;
  end

  // the single memory port never reads and writes in one cycle
  assert property (@(posedge clk) disable iff (rst)
    !(cmd.mem_rd && cmd.mem_wr))
    else $error("memory read and write in the same cycle");

  // a result is only loaded when the output register is free
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result overwrote a pending transaction");

  // reduced pages stay below the page count
  assert property (@(posedge clk) disable iff (rst)
    ({1'b0, src_pg} < PAGE_N) && ({1'b0, dst_pg} < PAGE_N))
    else $error("page remainder out of range");

endmodule

// ----- rtl/system_device_memory_copy_unit.sv -----
// top level of the system device memory copy unit
// depends on sdmc_pkg, sdmc_ctrl and sdmc_datapath
//
// system device with a paged byte memory of 16 pages of 64 KiB. each input
// transaction is one access (ram write, ram read, port write, port read) and
// gives exactly one output transaction holding the byte read, or zero for
// writes. a plain access goes from acceptance to the result being offered
// through accept, execute in the single-port memory or register file, and
// load the output register, which waits while the output register is full;
// the next input is taken once the controller is back in idle, even while the
// previous result still waits in the output register. a port 3 write runs a
// block copy: the command block is fetched a byte at a time, each read then
// captured (eleven bytes, or one when its first byte is not 1), then the
// source and destination pages are reduced modulo the page count by a
// reciprocal multiplication (quotient, then remainder), then each byte moves
// as a source read and a destination write through the one memory port. the
// memory has no reset; ports 4 and 5 read back the working and return stack
// pointers.
module system_device_memory_copy_unit #(
  parameter int PAGE_COUNT = sdmc_pkg::PAGE_COUNT_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // input transactions
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [sdmc_pkg::IN_USER_W-1:0]  s_tuser,  // action
  input  logic [sdmc_pkg::IN_DATA_W-1:0]  s_tdata,  // address[19:0], data[27:20], zero fill
  // output transactions
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [sdmc_pkg::BYTE_W-1:0]     m_tdata   // read_data
);

  // command and status between controller and datapath
  sdmc_pkg::ctrl_cmd_t  cmd;
  sdmc_pkg::dp_status_t status;

  sdmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sdmc_datapath #(
    .PAGE_COUNT (PAGE_COUNT)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

// ----- verif/system_device_memory_copy_unit_tb.sv -----
// self-checking testbench of the system device memory copy unit
// drives access transactions, predicts every result byte and checks the output stream
// depends on sdmc_pkg and system_device_memory_copy_unit
module system_device_memory_copy_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGES = sdmc_pkg::PAGE_COUNT_DEFAULT;
  localparam int ITEMS_PER_PHASE = 450;
  // longest quiet stretch: a 300 byte copy plus a long receiver stall, many times over
  localparam int QUIET_LIMIT = 20000;
  localparam int TAIL_CYCLES = 64;

  // device ports with no side effect
  localparam logic [sdmc_pkg::PORT_W-1:0] PORT_SPARE = 4'd9;
  localparam logic [sdmc_pkg::PORT_W-1:0] PORT_LAST  = 4'd15;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [sdmc_pkg::IN_USER_W-1:0] s_tuser = '0;   // action
  logic [sdmc_pkg::IN_DATA_W-1:0] s_tdata = '0;   // address[19:0], data[27:20], zero fill
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [sdmc_pkg::BYTE_W-1:0]    m_tdata;        // read_data

  system_device_memory_copy_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predicted device state
  // ---------------------------------------------------------------------------

  // sparse image of the paged memory: an entry exists only once the byte was written
  bit [7:0]  ram_image [bit [19:0]];
  bit [19:0] written_list [$];
  bit [7:0]  port_regs [sdmc_pkg::NUM_PORTS];
  bit [7:0]  work_sp;
  bit [7:0]  return_sp;

  // result bytes still owed by the block, oldest first
  bit [7:0]  expected_bytes [$];

  int        items_sent = 0;
  int        mismatch_count = 0;
  int        quiet_cycles = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;

  function automatic void store_byte(bit [19:0] addr, bit [7:0] value);
    if (!ram_image.exists(addr)) written_list.push_back(addr);
    ram_image[addr] = value;
  endfunction

  // big-endian 16 bit word at a flat address, no page wrap
  function automatic bit [15:0] word_at(bit [19:0] addr);
    return {ram_image[addr], ram_image[addr + 20'd1]};
  endfunction

  function automatic bit [19:0] page_base(bit [15:0] page);
    return 20'((page % PAGES) * 32'h10000);
  endfunction

  // byte i of a run, the offset wrapping inside its page
  function automatic bit [19:0] flat_addr(bit [19:0] base, bit [15:0] offs, int unsigned i);
    return base + 20'(16'(offs + i));
  endfunction

  function automatic void run_block_copy();
    bit [19:0]   blk;
    bit [19:0]   sbase;
    bit [19:0]   dbase;
    bit [15:0]   len;
    bit [15:0]   saddr;
    bit [15:0]   daddr;
    int unsigned i;
    blk = {4'h0, port_regs[sdmc_pkg::PORT_BLK_HI], port_regs[sdmc_pkg::PORT_BLK_LO]};
    if (ram_image[blk] != sdmc_pkg::CMD_COPY) return;
    len   = word_at(blk + 20'd1);
    sbase = page_base(word_at(blk + 20'd3));
    saddr = word_at(blk + 20'd5);
    dbase = page_base(word_at(blk + 20'd7));
    daddr = word_at(blk + 20'd9);
    // strictly forward, so an overlapping copy sees bytes already moved
    for (i = 0; i < len; i++)
      store_byte(flat_addr(dbase, daddr, i), ram_image[flat_addr(sbase, saddr, i)]);
  endfunction

  // one access against the predicted state, returning the byte the block owes
  function automatic bit [7:0] device_access(sdmc_pkg::action_t act, bit [19:0] addr,
                                             bit [7:0] data);
    bit [sdmc_pkg::PORT_W-1:0] port;
    bit [7:0]                  rd;
    port = addr[sdmc_pkg::PORT_W-1:0];
    rd   = '0;
    case (act)
      sdmc_pkg::ACT_RAM_WR: store_byte(addr, data);
      sdmc_pkg::ACT_RAM_RD: rd = ram_image[addr];
      sdmc_pkg::ACT_PORT_WR: begin
        port_regs[port] = data;
        if (port == sdmc_pkg::PORT_COPY) run_block_copy();
        else if (port == sdmc_pkg::PORT_WSP) work_sp = data;
        else if (port == sdmc_pkg::PORT_RSP) return_sp = data;
      end
      default: begin
        if (port == sdmc_pkg::PORT_WSP) rd = work_sp;
        else if (port == sdmc_pkg::PORT_RSP) rd = return_sp;
        else rd = port_regs[port];
      end
    endcase
    return rd;
  endfunction

  // true when a copy started from this block reads only bytes already written
  function automatic bit copy_ok(bit [19:0] blk);
    bit [19:0]   sbase;
    bit [15:0]   len;
    bit [15:0]   saddr;
    int unsigned i;
    if (!ram_image.exists(blk)) return 1'b0;
    if (ram_image[blk] != sdmc_pkg::CMD_COPY) return 1'b1;
    for (i = 1; i <= sdmc_pkg::HDR_BYTES; i++)
      if (!ram_image.exists(20'(blk + i))) return 1'b0;
    len   = word_at(blk + 20'd1);
    sbase = page_base(word_at(blk + 20'd3));
    saddr = word_at(blk + 20'd5);
    for (i = 0; i < len; i++)
      if (!ram_image.exists(flat_addr(sbase, saddr, i))) return 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] %s", $realtime, msg);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // offer one access, wait for the transaction and record what it must return;
  // a typed value replaces the predicted one where the answer is plain to see
  task automatic send_access(sdmc_pkg::action_t act, bit [19:0] addr, bit [7:0] data,
                             bit has_want = 1'b0, bit [7:0] want = 8'h00);
    bit [7:0] rd;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {4'h0, data, addr};
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    rd = device_access(act, addr, data);
    expected_bytes.push_back(has_want ? want : rd);
    items_sent++;
  endtask

  // hold off the sender until every owed result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_bytes.size() != 0);
  endtask

  // a complete copy: source bytes, command block, block address, trigger, read back
  task automatic send_copy_sequence();
    bit [15:0]   blk;
    bit [15:0]   len;
    bit [15:0]   spage;
    bit [15:0]   saddr;
    bit [15:0]   dpage;
    bit [15:0]   daddr;
    bit [19:0]   sbase;
    bit [19:0]   dbase;
    bit [19:0]   a;
    bit [7:0]    hdr [sdmc_pkg::HDR_BYTES+1];
    int unsigned i;
    int unsigned pick;
    // now and then the block straddles the end of page 0
    blk = ($urandom_range(7) == 0) ? 16'hFFF5 + 16'($urandom_range(10)) : 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 8) len = 16'd0;
    else if (pick < 70) len = 16'($urandom_range(1, 16));
    else if (pick < 95) len = 16'($urandom_range(17, 64));
    else len = 16'($urandom_range(65, 300));
    spage = 16'($urandom);
    saddr = ($urandom_range(3) == 0) ? 16'hFFFF - 16'($urandom_range(20)) : 16'($urandom);
    if ($urandom_range(3) == 0) begin
      // overlapping run in the same page
      dpage = spage;
      daddr = saddr + 16'($urandom_range(8)) - 16'd4;
    end else begin
      dpage = 16'($urandom);
      daddr = ($urandom_range(3) == 0) ? 16'hFFFF - 16'($urandom_range(20)) : 16'($urandom);
    end
    sbase = page_base(spage);
    dbase = page_base(dpage);
    hdr = '{sdmc_pkg::CMD_COPY, len[15:8], len[7:0], spage[15:8], spage[7:0],
            saddr[15:8], saddr[7:0], dpage[15:8], dpage[7:0], daddr[15:8], daddr[7:0]};
    // broken block: any other command byte leaves memory alone
    if ($urandom_range(9) == 0) hdr[0] = 8'($urandom_range(2, 256));

    for (i = 0; i < len; i++) begin
      a = flat_addr(sbase, saddr, i);
      if (!ram_image.exists(a)) send_access(sdmc_pkg::ACT_RAM_WR, a, 8'($urandom));
    end
    for (i = 0; i <= sdmc_pkg::HDR_BYTES; i++)
      send_access(sdmc_pkg::ACT_RAM_WR, {4'h0, blk} + 20'(i), hdr[i]);
    send_access(sdmc_pkg::ACT_PORT_WR, {16'($urandom), sdmc_pkg::PORT_BLK_HI}, blk[15:8]);
    send_access(sdmc_pkg::ACT_PORT_WR, {16'($urandom), sdmc_pkg::PORT_COPY}, blk[7:0]);
    if (hdr[0] == sdmc_pkg::CMD_COPY && len != 0)
      repeat ($urandom_range(1, 3))
        send_access(sdmc_pkg::ACT_RAM_RD, flat_addr(dbase, daddr, $urandom_range(len - 1)),
                    8'($urandom));
    if ($urandom_range(4) == 0) drain();
  endtask

  // a lone access; a port 3 write first gets a harmless or legal block under it
  task automatic send_noise();
    bit [19:0] addr;
    bit [19:0] blk;
    bit [7:0]  data;
    addr = 20'($urandom);
    data = 8'($urandom);
    case ($urandom_range(3))
      0: send_access(sdmc_pkg::ACT_RAM_WR, addr, data);
      1: send_access(sdmc_pkg::ACT_RAM_RD, written_list[$urandom_range(written_list.size() - 1)],
                     data);
      2: begin
        if (addr[sdmc_pkg::PORT_W-1:0] == sdmc_pkg::PORT_COPY) begin
          blk = {4'h0, port_regs[sdmc_pkg::PORT_BLK_HI], data};
          if (!copy_ok(blk)) send_access(sdmc_pkg::ACT_RAM_WR, blk, 8'($urandom_range(2, 256)));
        end
        send_access(sdmc_pkg::ACT_PORT_WR, addr, data);
      end
      default: send_access(sdmc_pkg::ACT_PORT_RD, addr, data);
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // opening rows: reset values, field extremes, every access kind, and the
  // copy corner cases (wrong command byte, block running into page 1,
  // destination page above the page count, destination at the page end)
  // ---------------------------------------------------------------------------

  typedef struct {
    sdmc_pkg::action_t act;
    bit [19:0]         addr;
    bit [7:0]          data;
    bit                has_want;
    bit [7:0]          want;
  } access_row_t;

  access_row_t opening_rows [26] = '{
    '{sdmc_pkg::ACT_PORT_RD, {16'h0000, sdmc_pkg::PORT_WSP},    8'h00, 1'b1, 8'h00},
    '{sdmc_pkg::ACT_PORT_RD, {16'hFFFF, PORT_LAST},             8'hFF, 1'b1, 8'h00},
    '{sdmc_pkg::ACT_RAM_WR,  20'h00000,                         8'hFF, 1'b1, 8'h00},
    '{sdmc_pkg::ACT_RAM_WR,  20'hFFFFF,                         8'h00, 1'b1, 8'h00},
    '{sdmc_pkg::ACT_RAM_RD,  20'h00000,                         8'h00, 1'b1, 8'hFF},
    '{sdmc_pkg::ACT_RAM_RD,  20'hFFFFF,                         8'hFF, 1'b1, 8'h00},
    '{sdmc_pkg::ACT_PORT_WR, {16'h0000, sdmc_pkg::PORT_WSP},    8'hFF, 1'b1, 8'h00},
    '{sdmc_pkg::ACT_PORT_RD, {16'h0000, sdmc_pkg::PORT_WSP},    8'h00, 1'b1, 8'hFF},
    '{sdmc_pkg::ACT_PORT_WR, {16'hFFFF, sdmc_pkg::PORT_RSP},    8'h5A, 1'b1, 8'h00},
    '{sdmc_pkg::ACT_PORT_RD, {16'h0000, sdmc_pkg::PORT_RSP},    8'h00, 1'b1, 8'h5A},
    '{sdmc_pkg::ACT_PORT_WR, {16'hABCD, PORT_SPARE},            8'hC3, 1'b1, 8'h00},
    // block at 0 starts with ff: the trigger only stores the register
    '{sdmc_pkg::ACT_PORT_WR, {16'h0000, sdmc_pkg::PORT_COPY},   8'h00, 1'b1, 8'h00},
    // block at ffff, its words in page 1: one byte from 00000 to page 13h mod 16, ffff
    '{sdmc_pkg::ACT_RAM_WR,  20'h0FFFF,                         8'h01, 1'b0, 8'h00},
    '{sdmc_pkg::ACT_RAM_WR,  20'h10000,                         8'h00, 1'b0, 8'h00},
    '{sdmc_pkg::ACT_RAM_WR,  20'h10001,                         8'h01, 1'b0, 8'h00},
    '{sdmc_pkg::ACT_RAM_WR,  20'h10002,                         8'h00, 1'b0, 8'h00},
    '{sdmc_pkg::ACT_RAM_WR,  20'h10003,                         8'h00, 1'b0, 8'h00},
    '{sdmc_pkg::ACT_RAM_WR,  20'h10004,                         8'h00, 1'b0, 8'h00},
    '{sdmc_pkg::ACT_RAM_WR,  20'h10005,                         8'h00, 1'b0, 8'h00},
    '{sdmc_pkg::ACT_RAM_WR,  20'h10006,                         8'h00, 1'b0, 8'h00},
    '{sdmc_pkg::ACT_RAM_WR,  20'h10007,                         8'h13, 1'b0, 8'h00},
    '{sdmc_pkg::ACT_RAM_WR,  20'h10008,                         8'hFF, 1'b0, 8'h00},
    '{sdmc_pkg::ACT_RAM_WR,  20'h10009,                         8'hFF, 1'b0, 8'h00},
    '{sdmc_pkg::ACT_PORT_WR, {16'h0000, sdmc_pkg::PORT_BLK_HI}, 8'hFF, 1'b1, 8'h00},
    '{sdmc_pkg::ACT_PORT_WR, {16'h0000, sdmc_pkg::PORT_COPY},   8'hFF, 1'b1, 8'h00},
    '{sdmc_pkg::ACT_RAM_RD,  20'h3FFFF,                         8'h00, 1'b1, 8'hFF}
  };

  // ---------------------------------------------------------------------------
  // output side: random back-pressure and in-order comparison
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : result_check
    bit [7:0] want;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("result %02h with nothing outstanding", m_tdata));
      end else begin
        want = expected_bytes.pop_front();
        if (m_tdata !== want)
          report_mismatch($sformatf("read_data %02h, predicted %02h", m_tdata, want));
      end
    end
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog: cycles in which neither side completes a transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("system_device_memory_copy_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------------

  initial begin : run
    int phase;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (phase = 0; phase < 3; phase++) begin
      // sender slow and receiver very slow, then the reverse, then full rate
      case (phase)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (phase == 0)
        foreach (opening_rows[r])
          send_access(opening_rows[r].act, opening_rows[r].addr, opening_rows[r].data,
                      opening_rows[r].has_want, opening_rows[r].want);
      // one pick in four is a whole copy sequence with random content, the rest lone accesses
      while (items_sent < (phase + 1) * ITEMS_PER_PHASE) begin
        if ($urandom_range(3) == 0) send_copy_sequence();
        else send_noise();
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_bytes.size() == 0)
      $display("system_device_memory_copy_unit: match");
    else
      $display("system_device_memory_copy_unit: mismatch");
    $finish;
  end

endmodule
